// ===== sv/mspg_pkg.sv =====
// Shared constants and types for the multi-stop gradient pixel unit.
package mspg_pkg;

    localparam int MAX_STOPS_DEF = 16;
    localparam int MAX_DIM       = 4096;

    localparam int DIM_W   = 13;  // image size registers, axis lengths, positions
    localparam int POS_W   = 12;  // pixel coordinates
    localparam int CH_W    = 16;  // stop channels
    localparam int COL_W   = 8;   // pixel channels
    localparam int IDX_W   = 4;   // stop index field
    localparam int DIR_W   = 2;
    localparam int CNT_W   = 5;   // stop count register
    localparam int MAG_W   = 24;  // dividends of the reciprocal divisions
    localparam int RCP_SH  = 24;  // reciprocal scale 2^24
    localparam int RCP_W   = 25;  // reciprocal width, holds 2^24
    localparam int STEP_W  = 25;  // signed DDA step
    localparam int LIM_W   = 14;
    localparam int STOP_W  = 3 * CH_W;

    localparam logic [RCP_W-1:0] RCP_ONE = RCP_W'(1) << RCP_SH;

    // configuration register indexes
    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_COUNT     = 2'd3;

    // gradient axis codes
    localparam logic [DIR_W-1:0] DIR_HORZ = 2'd0;
    localparam logic [DIR_W-1:0] DIR_VERT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DIAG = 2'd2;

    // request codes
    localparam logic REQ_STOP  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic simple;   // two-stop DDA on 8-bit ends
        logic flat;     // pixel past the last whole segment
    } t_lane_ctl;

endpackage

// ===== sv/multi_stop_gradient_pixel_unit.sv =====
// Top level: multi-stop linear gradient pixel source with stop table and constant setup.
//
//  channel   signals                                     carries
//  -------   -----------------------------------------   ------------------------------
//  request   i_valid / o_ready                           stop write or pixel coordinates
//  result    o_valid / i_ready                           8-bit RGB and outside flag
//  config    i_cfg_valid / o_cfg_ready, index, data      direction, width, height, count
//
//  One beat per cycle while o_ready is high (not during setup or a stalled result); stop writes give no result.
//  After reset and after each configuration write a serial divider works out the
//  segment length and two reciprocals, with o_ready low.
//  Reset is synchronous and clears the configuration, sequencer and valid registers; the stop table is not cleared.
//  A stalled result holds every stage; nothing is dropped or repeated.
module multi_stop_gradient_pixel_unit #(
    parameter int MAX_STOPS = mspg_pkg::MAX_STOPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [mspg_pkg::IDX_W-1:0]    i_stop_index,
    input  logic [mspg_pkg::CH_W-1:0]     i_stop_red,
    input  logic [mspg_pkg::CH_W-1:0]     i_stop_green,
    input  logic [mspg_pkg::CH_W-1:0]     i_stop_blue,
    input  logic [mspg_pkg::POS_W-1:0]    i_pixel_x,
    input  logic [mspg_pkg::POS_W-1:0]    i_pixel_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mspg_pkg::COL_W-1:0]    o_pix_red,
    output logic [mspg_pkg::COL_W-1:0]    o_pix_green,
    output logic [mspg_pkg::COL_W-1:0]    o_pix_blue,
    output logic                          o_outside_image,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [mspg_pkg::DIM_W-1:0]    i_cfg_data
);
    localparam int DW   = mspg_pkg::DIM_W;
    localparam int PW   = mspg_pkg::POS_W;
    localparam int MW   = mspg_pkg::MAG_W;
    localparam int RW   = mspg_pkg::RCP_W;
    localparam int LW   = mspg_pkg::LIM_W;
    localparam int STW  = mspg_pkg::STOP_W;
    localparam int CH   = mspg_pkg::CH_W;
    localparam int SW   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW   = $clog2(MAX_STOPS + 1);
    localparam int NSTG = 15;
    localparam int WSTG = 8;

    // setup sequencer states
    localparam logic [2:0] ST_SEG0 = 3'd0;
    localparam logic [2:0] ST_SEG1 = 3'd1;
    localparam logic [2:0] ST_RD0  = 3'd2;
    localparam logic [2:0] ST_RD1  = 3'd3;
    localparam logic [2:0] ST_RH0  = 3'd4;
    localparam logic [2:0] ST_RH1  = 3'd5;
    localparam logic [2:0] ST_LIM  = 3'd6;
    localparam logic [2:0] ST_IDLE = 3'd7;

    // ---------------- configuration ----------------
    logic [mspg_pkg::DIR_W-1:0] r_dir;
    logic [DW-1:0]              r_width, r_height;
    logic [mspg_pkg::CNT_W-1:0] r_count;
    logic                       cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= mspg_pkg::DIR_HORZ;
            r_width  <= DW'(1);
            r_height <= DW'(1);
            r_count  <= mspg_pkg::CNT_W'(1);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                mspg_pkg::REG_DIRECTION: r_dir    <= i_cfg_data[mspg_pkg::DIR_W-1:0];
                mspg_pkg::REG_WIDTH:     r_width  <= i_cfg_data;
                mspg_pkg::REG_HEIGHT:    r_height <= i_cfg_data;
                mspg_pkg::REG_COUNT:     r_count  <= i_cfg_data[mspg_pkg::CNT_W-1:0];
                default:                 r_dir    <= r_dir;
            endcase
        end
    end

    // clamped sizes and axis selection
    logic [DW-1:0] w_e, h_e, len, n_seg_div;
    logic [PW-1:0] wm1, hm1;
    logic [CW-1:0] n_e, c_hv, c_dg, cnt;
    logic          ax_v, ax_d, multi;

    always_comb begin
        w_e = (r_width == '0) ? DW'(1) :
              (r_width > DW'(mspg_pkg::MAX_DIM)) ? DW'(mspg_pkg::MAX_DIM) : r_width;
        h_e = (r_height == '0) ? DW'(1) :
              (r_height > DW'(mspg_pkg::MAX_DIM)) ? DW'(mspg_pkg::MAX_DIM) : r_height;
        wm1 = PW'(w_e - DW'(1));
        hm1 = (h_e == DW'(1)) ? PW'(1) : PW'(h_e - DW'(1));
        n_e = (r_count == '0) ? CW'(1) :
              (32'(r_count) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(r_count);
        ax_v = (r_dir == mspg_pkg::DIR_VERT) || (r_dir == mspg_pkg::DIR_DIAG && w_e == DW'(1));
        ax_d = (r_dir == mspg_pkg::DIR_DIAG) && !ax_v && (h_e != DW'(1));
        len  = ax_v ? h_e : ax_d ? DW'({w_e, 1'b0} - (DW+1)'(1)) : w_e;
        c_hv = (DW'(n_e) > len) ? CW'(len) : n_e;
        c_dg = (DW'(n_e) > w_e) ? CW'(w_e) : n_e;
        c_dg = (DW'(c_dg) > h_e) ? CW'(h_e) : c_dg;
        multi = (n_e > CW'(2)) && !(ax_d && c_dg <= CW'(2));
        cnt   = ax_d ? c_dg : c_hv;
        n_seg_div = (multi && cnt > CW'(1)) ? DW'(cnt - CW'(1)) : DW'(1);
    end

    // derived constants, settled by the sequencer
    logic [2:0]    r_st;
    logic          r_simple, r_b, r_ax_v, r_ax_d;
    logic [CW-1:0] r_cnt_m1;
    logic [DW-1:0] r_seg;
    logic [RW-1:0] r_rd, r_rh;
    logic [LW-1:0] r_limit;
    logic          div_start, div_done;
    logic [RW-1:0] div_dividend, div_quo;
    logic [DW-1:0] div_divisor;
    logic [DW+CW-1:0] lim_prod;

    always_comb begin
        div_start    = (r_st == ST_SEG0) || (r_st == ST_RD0) || (r_st == ST_RH0);
        div_dividend = (r_st == ST_SEG0) ? RW'(len) : mspg_pkg::RCP_ONE;
        case (r_st)
            ST_SEG0: div_divisor = n_seg_div;
            ST_RD0:  div_divisor = r_seg;
            default: div_divisor = DW'(hm1);
        endcase
        lim_prod = (DW+CW)'(r_seg) * (DW+CW)'(r_cnt_m1);
    end

    mspg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_SEG0;
        end else if (cfg_wr) begin
            r_st <= ST_SEG0;
        end else begin
            case (r_st)
                ST_SEG0: r_st <= ST_SEG1;
                ST_SEG1: if (div_done) begin
                    r_st <= ST_RD0;
                end
                ST_RD0:  r_st <= ST_RD1;
                ST_RD1:  if (div_done) begin
                    r_st <= ST_RH0;
                end
                ST_RH0:  r_st <= ST_RH1;
                ST_RH1:  if (div_done) begin
                    r_st <= ST_LIM;
                end
                ST_LIM:  r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_SEG0) begin
            r_simple <= !multi;
            r_b      <= (n_e >= CW'(2));
            r_ax_v   <= ax_v;
            r_ax_d   <= ax_d;
            r_cnt_m1 <= cnt - CW'(1);
        end
        if (r_st == ST_SEG1 && div_done) begin
            r_seg <= div_quo[DW-1:0];
        end
        if (r_st == ST_RD1 && div_done) begin
            r_rd <= div_quo;
        end
        if (r_st == ST_RH1 && div_done) begin
            r_rh <= div_quo;
        end
        if (r_st == ST_LIM) begin
            r_limit <= r_simple ? '1 : LW'(lim_prod);
        end
    end

    // ---------------- pixel pipeline ----------------
    logic en, in_acc;
    logic r_vld [1:NSTG];
    logic r_pix [1:NSTG];
    logic r_oob [1:NSTG];
    logic [mspg_pkg::IDX_W-1:0] r_widx [1:WSTG];
    logic [STW-1:0]             r_wdat [1:WSTG];

    assign en      = !(r_vld[NSTG] && r_pix[NSTG]) || i_ready;
    assign o_ready = en && (r_st == ST_IDLE);
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= in_acc;
            for (int k = 2; k <= NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pix[1]  <= (i_req_type == mspg_pkg::REQ_PIXEL);
            r_oob[1]  <= ({1'b0, i_pixel_x} >= w_e) || ({1'b0, i_pixel_y} >= h_e);
            r_widx[1] <= i_stop_index;
            r_wdat[1] <= {i_stop_red, i_stop_green, i_stop_blue};
            for (int k = 2; k <= NSTG; k++) begin
                r_pix[k] <= r_pix[k-1];
                r_oob[k] <= r_oob[k-1];
            end
            for (int k = 2; k <= WSTG; k++) begin
                r_widx[k] <= r_widx[k-1];
                r_wdat[k] <= r_wdat[k-1];
            end
        end
    end

    // position datapath
    logic [PW-1:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y, r4_x, r4_y, r4_qh;
    logic [MW-1:0] r1_py, r2_py, r3_py, r2_qh0, r3_qh0, r3_qhd;
    logic [DW-1:0] r5_p, r6_p, r7_p, r6_qp0, r7_qp0, r7_qpd, r8_q, r8_j, r9_j;
    logic          r6_flat, r7_flat, r8_flat, r9_flat;
    logic [STW-1:0] r9_a, r9_b;

    logic [MW+RW-1:0] t2;
    logic [MW+PW-1:0] t3;
    logic [MW-1:0]    rh;
    logic [DW+RW-1:0] t6;
    logic [2*DW-1:0]  t7;
    logic [DW-1:0]    rp;
    logic [SW-1:0]    addr_a, addr_b;
    logic [STW-1:0]   r_stop_mem [MAX_STOPS];

    always_comb begin
        t2 = (MW+RW)'(r1_py) * (MW+RW)'(r_rh);
        t3 = (MW+PW)'(r2_qh0) * (MW+PW)'(hm1);
        rh = r3_py - r3_qhd;
        t6 = (DW+RW)'(r5_p) * (DW+RW)'(r_rd);
        t7 = (2*DW)'(r6_qp0) * (2*DW)'(r_seg);
        rp = r7_p - r7_qpd;
        addr_a = r_simple ? SW'(0) : r8_flat ? SW'(r_cnt_m1) : r8_q[SW-1:0];
        addr_b = r_simple ? SW'(r_b) : SW'(r8_q + DW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x  <= i_pixel_x;
            r1_y  <= i_pixel_y;
            r1_py <= MW'(i_pixel_y) * MW'(wm1);

            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_py  <= r1_py;
            r2_qh0 <= t2[mspg_pkg::RCP_SH+MW-1:mspg_pkg::RCP_SH];

            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_py  <= r2_py;
            r3_qh0 <= r2_qh0;
            r3_qhd <= t3[MW-1:0];

            // correct the reciprocal quotient by one where it fell short
            r4_x  <= r3_x;
            r4_y  <= r3_y;
            r4_qh <= (rh >= MW'(hm1)) ? PW'(r3_qh0 + MW'(1)) : PW'(r3_qh0);

            r5_p <= r_ax_d ? DW'(r4_x) + DW'(r4_qh) : r_ax_v ? DW'(r4_y) : DW'(r4_x);

            r6_p    <= r5_p;
            r6_qp0  <= t6[mspg_pkg::RCP_SH+DW-1:mspg_pkg::RCP_SH];
            r6_flat <= ({1'b0, r5_p} >= r_limit);

            r7_p    <= r6_p;
            r7_qp0  <= r6_qp0;
            r7_qpd  <= t7[DW-1:0];
            r7_flat <= r6_flat;

            r8_q    <= (rp >= r_seg) ? r7_qp0 + DW'(1) : r7_qp0;
            r8_j    <= (rp >= r_seg) ? rp - r_seg : rp;
            r8_flat <= r7_flat;

            r9_j    <= r8_j;
            r9_flat <= r8_flat;
        end
    end

    // stop table: writes and reads at the same stage keep request order
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_vld[WSTG] && !r_pix[WSTG] && (32'(r_widx[WSTG]) < MAX_STOPS)) begin
                r_stop_mem[SW'(r_widx[WSTG])] <= r_wdat[WSTG];
            end
            r9_a <= r_stop_mem[addr_a];
            r9_b <= r_stop_mem[addr_b];
        end
    end

    mspg_pkg::t_lane_ctl lane_ctl;
    logic [mspg_pkg::COL_W-1:0] col_r, col_g, col_b;

    assign lane_ctl.simple = r_simple;
    assign lane_ctl.flat   = r9_flat;

    mspg_lane u_lane_r (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_start (r9_a[3*CH-1:2*CH]),
        .i_end   (r9_b[3*CH-1:2*CH]),
        .i_j     (r9_j),
        .i_ctl   (lane_ctl),
        .i_seg   (r_seg),
        .i_recip (r_rd),
        .o_color (col_r)
    );

    mspg_lane u_lane_g (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_start (r9_a[2*CH-1:CH]),
        .i_end   (r9_b[2*CH-1:CH]),
        .i_j     (r9_j),
        .i_ctl   (lane_ctl),
        .i_seg   (r_seg),
        .i_recip (r_rd),
        .o_color (col_g)
    );

    mspg_lane u_lane_b (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_start (r9_a[CH-1:0]),
        .i_end   (r9_b[CH-1:0]),
        .i_j     (r9_j),
        .i_ctl   (lane_ctl),
        .i_seg   (r_seg),
        .i_recip (r_rd),
        .o_color (col_b)
    );

    // drop stop-write beats at the output; zero colors outside the image
    assign o_valid         = r_vld[NSTG] && r_pix[NSTG];
    assign o_outside_image = r_oob[NSTG];
    assign o_pix_red       = r_oob[NSTG] ? '0 : col_r;
    assign o_pix_green     = r_oob[NSTG] ? '0 : col_g;
    assign o_pix_blue      = r_oob[NSTG] ? '0 : col_b;

endmodule

// ===== sv/mspg_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-configuration constants.
module mspg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mspg_pkg::RCP_W-1:0]   i_dividend,
    input  logic [mspg_pkg::DIM_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [mspg_pkg::RCP_W-1:0]   o_quotient
);
    localparam int QW = mspg_pkg::RCP_W;
    localparam int DW = mspg_pkg::DIM_W;
    localparam int KW = $clog2(QW + 1);

    logic [KW-1:0] r_cnt;
    logic          r_done;
    logic [QW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   n_sh;
    logic          n_bit;
    logic [DW:0]   n_diff;

    always_comb begin
        n_sh   = {r_rem, r_quo[QW-1]};
        n_diff = n_sh - {1'b0, r_dvs};
        n_bit  = (n_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= KW'(QW);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == KW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[QW-2:0], n_bit};
            r_rem <= n_bit ? n_diff[DW-1:0] : n_sh[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/mspg_lane.sv =====
// One color channel: step division by reciprocal, DDA multiply and 8-bit extract.
module mspg_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [mspg_pkg::CH_W-1:0]    i_start,
    input  logic [mspg_pkg::CH_W-1:0]    i_end,
    input  logic [mspg_pkg::DIM_W-1:0]   i_j,
    input  mspg_pkg::t_lane_ctl          i_ctl,
    input  logic [mspg_pkg::DIM_W-1:0]   i_seg,
    input  logic [mspg_pkg::RCP_W-1:0]   i_recip,
    output logic [mspg_pkg::COL_W-1:0]   o_color
);
    localparam int MW = mspg_pkg::MAG_W;
    localparam int DW = mspg_pkg::DIM_W;
    localparam int SW = mspg_pkg::STEP_W;
    localparam int CW = mspg_pkg::COL_W;
    localparam int RW = mspg_pkg::RCP_W;
    localparam int CH_HI  = mspg_pkg::CH_W - 1;
    localparam int RCP_HI = mspg_pkg::RCP_SH + MW - 1;

    // stage 1
    logic [MW-1:0] r1_s, r1_mag;
    logic          r1_neg;
    logic [DW-1:0] r1_j;
    mspg_pkg::t_lane_ctl r1_ctl;
    logic [CW-1:0] r1_fb;
    // stage 2
    logic [MW-1:0] r2_s, r2_mag, r2_q0;
    logic          r2_neg;
    logic [DW-1:0] r2_j;
    mspg_pkg::t_lane_ctl r2_ctl;
    logic [CW-1:0] r2_fb;
    // stage 3
    logic [MW-1:0] r3_s, r3_mag, r3_q0, r3_qd;
    logic          r3_neg;
    logic [DW-1:0] r3_j;
    mspg_pkg::t_lane_ctl r3_ctl;
    logic [CW-1:0] r3_fb;
    // stage 4
    logic [MW-1:0] r4_s;
    logic signed [SW-1:0] r4_step;
    logic [DW-1:0] r4_j;
    mspg_pkg::t_lane_ctl r4_ctl;
    logic [CW-1:0] r4_fb;
    // stage 5
    logic [MW-1:0] r5_s;
    logic signed [SW-1:0] r5_prod;
    mspg_pkg::t_lane_ctl r5_ctl;
    logic [CW-1:0] r5_fb;
    // stage 6
    logic [CW-1:0] r6_color;

    logic [MW-1:0]        n_sv, n_ev;
    logic [MW+RW-1:0]     n_t2;
    logic [MW+DW-1:0]     n_t3;
    logic [MW-1:0]        n_rem, n_q;
    logic signed [SW-1:0] n_qs;
    logic signed [DW:0]   n_js;
    logic signed [DW+SW:0] n_prod;
    logic signed [MW+1:0] n_v;
    logic [CW-1:0]        n_color;

    always_comb begin
        n_sv = i_ctl.simple ? {i_start[CH_HI:CH_HI-7], 16'h0} : {i_start, 8'h0};
        n_ev = i_ctl.simple ? {i_end[CH_HI:CH_HI-7], 16'h0} : {i_end, 8'h0};
        n_t2 = (MW+RW)'(r1_mag) * (MW+RW)'(i_recip);
        n_t3 = (MW+DW)'(r2_q0) * (MW+DW)'(i_seg);
        n_rem = r3_mag - r3_qd;
        n_q   = (n_rem >= MW'(i_seg)) ? r3_q0 + MW'(1) : r3_q0;
        n_qs  = $signed({1'b0, n_q});
        n_js  = $signed({1'b0, r4_j});
        n_prod = n_js * r4_step;
        n_v   = $signed({2'b00, r5_s}) + $signed({r5_prod[SW-1], r5_prod});
        if (r5_ctl.flat) begin
            n_color = r5_fb;
        end else if (n_v[MW+1]) begin
            n_color = '0;
        end else begin
            n_color = n_v[MW-1:MW-CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s   <= n_sv;
            r1_neg <= (n_ev < n_sv);
            r1_mag <= (n_ev < n_sv) ? n_sv - n_ev : n_ev - n_sv;
            r1_j   <= i_j;
            r1_ctl <= i_ctl;
            r1_fb  <= i_start[CH_HI:CH_HI-7];

            r2_s   <= r1_s;
            r2_mag <= r1_mag;
            r2_q0  <= n_t2[RCP_HI:mspg_pkg::RCP_SH];
            r2_neg <= r1_neg;
            r2_j   <= r1_j;
            r2_ctl <= r1_ctl;
            r2_fb  <= r1_fb;

            r3_s   <= r2_s;
            r3_mag <= r2_mag;
            r3_q0  <= r2_q0;
            r3_qd  <= n_t3[MW-1:0];
            r3_neg <= r2_neg;
            r3_j   <= r2_j;
            r3_ctl <= r2_ctl;
            r3_fb  <= r2_fb;

            r4_s    <= r3_s;
            r4_step <= r3_neg ? -n_qs : n_qs;
            r4_j    <= r3_j;
            r4_ctl  <= r3_ctl;
            r4_fb   <= r3_fb;

            r5_s    <= r4_s;
            r5_prod <= n_prod[SW-1:0];
            r5_ctl  <= r4_ctl;
            r5_fb   <= r4_fb;

            r6_color <= n_color;
        end
    end

    assign o_color = r6_color;

endmodule

// ===== tb/sv/multi_stop_gradient_pixel_unit_tb.sv =====
// Self-checking testbench for the multi-stop gradient pixel unit.
`timescale 1ns / 100ps

module multi_stop_gradient_pixel_unit_tb;

    typedef struct packed {
        bit [mspg_pkg::COL_W-1:0] red;
        bit [mspg_pkg::COL_W-1:0] green;
        bit [mspg_pkg::COL_W-1:0] blue;
        bit                       outside;
    } t_pixel;

    class t_gradient_scoreboard;
        bit [mspg_pkg::CH_W-1:0]  stop_ch[mspg_pkg::MAX_STOPS_DEF][3];
        bit [mspg_pkg::DIR_W-1:0] dir;
        longint         width_reg, height_reg, count_reg;
        t_pixel         expected_pix[$];
        int             mismatches;
        int             pixels_checked;

        function new();
            dir = mspg_pkg::DIR_HORZ;
            width_reg = 1;
            height_reg = 1;
            count_reg = 1;
            mismatches = 0;
            pixels_checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [mspg_pkg::DIM_W-1:0] data);
            case (idx)
                mspg_pkg::REG_DIRECTION: dir = data[mspg_pkg::DIR_W-1:0];
                mspg_pkg::REG_WIDTH:     width_reg = data;
                mspg_pkg::REG_HEIGHT:    height_reg = data;
                mspg_pkg::REG_COUNT:     count_reg = data[mspg_pkg::CNT_W-1:0];
                default:                 dir = dir;
            endcase
        endfunction

        function bit [mspg_pkg::COL_W-1:0] dda(longint s, longint e, longint len,
                                               longint pos);
            longint step;
            longint v;
            step = (e - s) / len;
            v = s + pos * step;
            if (v < 0) v = 0;
            return v[23:16];
        endfunction

        function t_pixel two_stop(longint len, longint pos, int a, int b);
            t_pixel p;
            bit [mspg_pkg::COL_W-1:0] ch[3];
            for (int c = 0; c < 3; c++)
                ch[c] = dda(longint'(stop_ch[a][c] >> 8) * 65536,
                            longint'(stop_ch[b][c] >> 8) * 65536, len, pos);
            p = '{ch[0], ch[1], ch[2], 1'b0};
            return p;
        endfunction

        function t_pixel segmented(longint len, longint pos, longint count);
            t_pixel p;
            bit [mspg_pkg::COL_W-1:0] ch[3];
            longint seg, i, j;
            if (count > len) count = len;
            seg = (count > 1) ? len / (count - 1) : len;
            if (count > 1 && pos < seg * (count - 1)) begin
                i = pos / seg + 1;
                j = pos % seg;
                for (int c = 0; c < 3; c++)
                    ch[c] = dda(longint'(stop_ch[i-1][c]) * 256,
                                longint'(stop_ch[i][c]) * 256, seg, j);
            end else begin
                for (int c = 0; c < 3; c++)
                    ch[c] = stop_ch[count-1][c][15:8];
            end
            p = '{ch[0], ch[1], ch[2], 1'b0};
            return p;
        endfunction

        function t_pixel predict_pixel(longint x, longint y);
            longint w, h, n, cnt, pos;
            bit vert, horz;
            w = (width_reg < 1) ? 1 :
                (width_reg > mspg_pkg::MAX_DIM) ? mspg_pkg::MAX_DIM : width_reg;
            h = (height_reg < 1) ? 1 :
                (height_reg > mspg_pkg::MAX_DIM) ? mspg_pkg::MAX_DIM : height_reg;
            n = (count_reg < 1) ? 1 :
                (count_reg > mspg_pkg::MAX_STOPS_DEF) ? mspg_pkg::MAX_STOPS_DEF : count_reg;
            if (x >= w || y >= h) return '{8'd0, 8'd0, 8'd0, 1'b1};
            vert = (dir == mspg_pkg::DIR_VERT) || (dir == mspg_pkg::DIR_DIAG && w == 1);
            horz = !vert && (dir != mspg_pkg::DIR_DIAG || h == 1);
            pos = x + (y * (w - 1)) / ((h > 1) ? h - 1 : 1);
            if (n <= 2) begin
                if (vert) return two_stop(h, y, 0, (n == 2) ? 1 : 0);
                if (horz) return two_stop(w, x, 0, (n == 2) ? 1 : 0);
                return two_stop(2 * w - 1, pos, 0, (n == 2) ? 1 : 0);
            end
            if (vert) return segmented(h, y, n);
            if (horz) return segmented(w, x, n);
            cnt = n;
            if (cnt > w) cnt = w;
            if (cnt > h) cnt = h;
            if (cnt > 2) return segmented(2 * w - 1, pos, cnt);
            return two_stop(2 * w - 1, pos, 0, 1);
        endfunction

        function void note_request(logic req, logic [mspg_pkg::IDX_W-1:0] idx,
                                   logic [mspg_pkg::CH_W-1:0] r,
                                   logic [mspg_pkg::CH_W-1:0] g,
                                   logic [mspg_pkg::CH_W-1:0] b,
                                   logic [mspg_pkg::POS_W-1:0] x,
                                   logic [mspg_pkg::POS_W-1:0] y);
            if (req == mspg_pkg::REQ_STOP) begin
                stop_ch[idx][0] = r;
                stop_ch[idx][1] = g;
                stop_ch[idx][2] = b;
            end else begin
                expected_pix.push_back(predict_pixel(x, y));
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel exp_p;
            if (expected_pix.size() == 0) begin
                $display("%0t: unexpected pixel %p", $time, got);
                mismatches++;
                return;
            end
            exp_p = expected_pix.pop_front();
            pixels_checked++;
            if (got.red !== exp_p.red)
                $display("%0t: red exp %0d got %0d", $time, exp_p.red, got.red);
            if (got.green !== exp_p.green)
                $display("%0t: green exp %0d got %0d", $time, exp_p.green, got.green);
            if (got.blue !== exp_p.blue)
                $display("%0t: blue exp %0d got %0d", $time, exp_p.blue, got.blue);
            if (got.outside !== exp_p.outside)
                $display("%0t: outside exp %0d got %0d", $time, exp_p.outside, got.outside);
            if (got !== exp_p) mismatches++;
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_req_type;
    logic [mspg_pkg::IDX_W-1:0]    i_stop_index;
    logic [mspg_pkg::CH_W-1:0]     i_stop_red, i_stop_green, i_stop_blue;
    logic [mspg_pkg::POS_W-1:0]    i_pixel_x, i_pixel_y;
    logic                          o_valid;
    logic                          i_ready;
    logic [mspg_pkg::COL_W-1:0]    o_pix_red, o_pix_green, o_pix_blue;
    logic                          o_outside_image;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index;
    logic [mspg_pkg::DIM_W-1:0]    i_cfg_data;

    t_gradient_scoreboard board;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  quiet_cycles;
    int                  stops_sent;
    int                  settings_used;

    multi_stop_gradient_pixel_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_pixel('{o_pix_red, o_pix_green, o_pix_blue, o_outside_image});
    end

    // count cycles in which no beat moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(logic req, logic [mspg_pkg::IDX_W-1:0] idx,
                             logic [mspg_pkg::CH_W-1:0] r,
                             logic [mspg_pkg::CH_W-1:0] g,
                             logic [mspg_pkg::CH_W-1:0] b,
                             logic [mspg_pkg::POS_W-1:0] x,
                             logic [mspg_pkg::POS_W-1:0] y);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_stop_index <= idx;
        i_stop_red   <= r;
        i_stop_green <= g;
        i_stop_blue  <= b;
        i_pixel_x    <= x;
        i_pixel_y    <= y;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(req, idx, r, g, b, x, y);
        if (req == mspg_pkg::REQ_STOP) stops_sent++;
    endtask

    task automatic drain_pixels();
        i_valid <= 1'b0;
        while (board.expected_pix.size() > 0) @(posedge i_clk);
        // a stop write may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [mspg_pkg::DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
    endtask

    task automatic apply_setting(logic [mspg_pkg::DIM_W-1:0] dir,
                                 logic [mspg_pkg::DIM_W-1:0] w,
                                 logic [mspg_pkg::DIM_W-1:0] h,
                                 logic [mspg_pkg::DIM_W-1:0] n);
        drain_pixels();
        write_reg(mspg_pkg::REG_DIRECTION, dir);
        write_reg(mspg_pkg::REG_WIDTH, w);
        write_reg(mspg_pkg::REG_HEIGHT, h);
        write_reg(mspg_pkg::REG_COUNT, n);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [mspg_pkg::CH_W-1:0] rand_channel();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return mspg_pkg::CH_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel_in_range();
        longint w, h;
        w = (board.width_reg < 1) ? 1 :
            (board.width_reg > mspg_pkg::MAX_DIM) ? mspg_pkg::MAX_DIM : board.width_reg;
        h = (board.height_reg < 1) ? 1 :
            (board.height_reg > mspg_pkg::MAX_DIM) ? mspg_pkg::MAX_DIM : board.height_reg;
        if ($urandom_range(99) < 85)
            send_beat(mspg_pkg::REQ_PIXEL, '0, '0, '0, '0,
                      mspg_pkg::POS_W'($urandom_range(w - 1)),
                      mspg_pkg::POS_W'($urandom_range(h - 1)));
        else
            send_beat(mspg_pkg::REQ_PIXEL, mspg_pkg::IDX_W'($urandom),
                      mspg_pkg::CH_W'($urandom), mspg_pkg::CH_W'($urandom),
                      mspg_pkg::CH_W'($urandom), mspg_pkg::POS_W'($urandom),
                      mspg_pkg::POS_W'($urandom));
    endtask

    initial begin
        board = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stops_sent = 0;
        settings_used = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= mspg_pkg::REQ_STOP;
        i_stop_index <= '0;
        i_stop_red   <= '0;
        i_stop_green <= '0;
        i_stop_blue  <= '0;
        i_pixel_x    <= '0;
        i_pixel_y    <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= mspg_pkg::REG_DIRECTION;
        i_cfg_data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table first so no unwritten stop is ever read
        for (int s = 0; s < mspg_pkg::MAX_STOPS_DEF; s++)
            send_beat(mspg_pkg::REQ_STOP, mspg_pkg::IDX_W'(s),
                      (s % 2) ? 16'hFFFF : 16'h0000,
                      (s % 3 == 0) ? 16'hFF00 : 16'h00FF,
                      mspg_pkg::CH_W'(s * 4369), '0, '0);
        apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_HORZ), 13'd4096, 13'd4096, 13'd16);
        send_beat(mspg_pkg::REQ_PIXEL, '0, '0, '0, '0, 12'd0, 12'd0);
        send_beat(mspg_pkg::REQ_PIXEL, '0, '0, '0, '0, 12'd4095, 12'd4095);
        send_beat(mspg_pkg::REQ_PIXEL, '0, '0, '0, '0, 12'd4094, 12'd17);
        apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_DIAG), 13'd7, 13'd5, 13'd2);
        send_beat(mspg_pkg::REQ_PIXEL, '0, '0, '0, '0, 12'd6, 12'd4);
        send_beat(mspg_pkg::REQ_PIXEL, '0, '0, '0, '0, 12'd7, 12'd0);
        send_beat(mspg_pkg::REQ_PIXEL, '0, '0, '0, '0, 12'd0, 12'd5);

        for (int ph = 0; ph < 15; ph++) begin
            case (ph)
                0: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_HORZ),
                                 13'd4096, 13'd1, 13'd16);
                1: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_VERT),
                                 13'd1, 13'd4096, 13'd2);
                2: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_DIAG),
                                 13'd4096, 13'd4096, 13'd16);
                3: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_DIAG),
                                 13'd1, 13'd50, 13'd5);
                4: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_DIAG),
                                 13'd50, 13'd1, 13'd3);
                5: apply_setting(13'd3, 13'd0, 13'd0, 13'd0);
                6: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_DIAG),
                                 13'd8191, 13'd5000, 13'd31);
                7: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_DIAG),
                                 13'd3, 13'd2, 13'd16);
                8: apply_setting(mspg_pkg::DIM_W'(mspg_pkg::DIR_VERT),
                                 13'd9, 13'd20, 13'd1);
                default: apply_setting(mspg_pkg::DIM_W'($urandom_range(3)),
                                       mspg_pkg::DIM_W'(($urandom_range(9) == 0) ? $urandom
                                              : $urandom_range(1, 300)),
                                       mspg_pkg::DIM_W'(($urandom_range(9) == 0) ? $urandom
                                              : $urandom_range(1, 300)),
                                       mspg_pkg::DIM_W'($urandom_range(31)));
            endcase
            send_idle_pct = (ph < 5) ? 20 : (ph < 10) ? 72 : 0;
            recv_idle_pct = (ph < 5) ? 72 : (ph < 10) ? 20 : 0;
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(99) < 25)
                    send_beat(mspg_pkg::REQ_STOP, mspg_pkg::IDX_W'($urandom),
                              rand_channel(), rand_channel(), rand_channel(),
                              mspg_pkg::POS_W'($urandom), mspg_pkg::POS_W'($urandom));
                else
                    send_pixel_in_range();
            end
        end

        drain_pixels();
        $display("Covered %0d pixels and %0d stop writes over %0d register settings,",
                 board.pixels_checked, stops_sent, settings_used);
        $display("all axes, clamped sizes and counts, under sender and receiver stalls.");
        if (board.mismatches == 0 && board.expected_pix.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d pixels missing", board.mismatches,
                     board.expected_pix.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
